>>> src/cc2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc2p_pkg
// Shared widths, constants and types of the CORDIC Cartesian-to-polar block.
// ----------------------------------------------------------------------------
package cc2p_pkg;

    localparam int IO_W        = 16;
    localparam int FRAC_BITS   = 13;
    localparam int ITERATIONS  = 11;
    localparam int TABLE_SIZE  = 16;
    localparam int SHIFT_W     = $clog2(TABLE_SIZE);

    // datapath x/y: gain growth on a 17-bit rotated point stays below 2^18
    localparam int DP_W        = 20;
    // angle accumulator: +/-(pi/2 + sum of atan) stays well inside 17 bits
    localparam int ANG_W       = 17;
    localparam int ATAN_W      = 14;

    localparam int HALF_PI_POS = 12867;
    localparam int HALF_PI_NEG = -12868;
    localparam int GAIN_Q13    = 13489;

    // floor(x * 2^13 / GAIN) by reciprocal multiply, one-step correction
    localparam int    RECIP_SHIFT = 20;
    localparam longint RECIP      = (64'sd1 <<< (RECIP_SHIFT + FRAC_BITS)) / GAIN_Q13;
    localparam int    RECIP_W     = 21;
    localparam int    PROD_W      = DP_W + RECIP_W;
    localparam int    REM_W       = DP_W + 16;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    localparam logic [ATAN_W-1:0] ATAN_Q13 [TABLE_SIZE] = '{
        14'd6433, 14'd3798, 14'd2006, 14'd1018, 14'd511, 14'd255, 14'd127, 14'd63,
        14'd31,   14'd15,   14'd7,    14'd3,    14'd1,   14'd0,   14'd0,   14'd0
    };

    typedef struct packed {
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ANG_W-1:0] th;
    } t_vec;

    typedef struct packed {
        logic signed [DP_W-1:0]  q;
        logic signed [ANG_W-1:0] th;
    } t_polar;

endpackage

`default_nettype wire

>>> src/cc2p_iter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc2p_iter
// One registered CORDIC vectoring micro-rotation; shift index is tied per stage.
// ----------------------------------------------------------------------------
module cc2p_iter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire  [cc2p_pkg::SHIFT_W-1:0] i_shift,
    input  wire                          i_valid,
    input  cc2p_pkg::t_vec               i_vec,
    output logic                         o_valid,
    output cc2p_pkg::t_vec               o_vec
);
    import cc2p_pkg::*;

    logic signed [DP_W-1:0]  x;
    logic signed [DP_W-1:0]  y;
    logic signed [DP_W-1:0]  neg_x;
    logic signed [DP_W-1:0]  neg_y;
    logic signed [DP_W-1:0]  sx;
    logic signed [DP_W-1:0]  sy;
    logic signed [ANG_W-1:0] atan_v;
    logic                    pos;
    t_vec                    n_vec;
    logic                    r_valid;
    t_vec                    r_vec;

    always_comb begin
        x      = i_vec.x;
        y      = i_vec.y;
        neg_x  = -x;
        neg_y  = -y;
        pos    = (y > 0);
        atan_v = $signed(ANG_W'(ATAN_Q13[i_shift]));
        // true negation before the floor shift when y is positive
        sx     = pos ? (neg_x >>> i_shift) : (x >>> i_shift);
        sy     = pos ? (neg_y >>> i_shift) : (y >>> i_shift);
        n_vec.x  = x - sy;
        n_vec.y  = y + sx;
        n_vec.th = pos ? (i_vec.th + atan_v) : (i_vec.th - atan_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

>>> src/cc2p_gain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc2p_gain
// Three-stage floor division of the final x by the CORDIC gain (Q13).
// ----------------------------------------------------------------------------
module cc2p_gain (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  cc2p_pkg::t_vec   i_vec,
    output logic             o_valid,
    output cc2p_pkg::t_polar o_polar
);
    import cc2p_pkg::*;

    logic signed [RECIP_W-1:0] recip_c;
    logic signed [REM_W-1:0]   gain_c;
    logic signed [DP_W-1:0]    x_in;

    logic                      r_v1;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DP_W-1:0]    r_x1;
    logic signed [ANG_W-1:0]   r_th1;

    logic signed [DP_W-1:0]    q_est;
    logic signed [REM_W-1:0]   num;
    logic signed [REM_W-1:0]   n_rem;

    logic                      r_v2;
    logic signed [DP_W-1:0]    r_q2;
    logic signed [REM_W-1:0]   r_rem;
    logic signed [ANG_W-1:0]   r_th2;

    t_polar                    n_polar;
    logic                      r_v3;
    t_polar                    r_polar;

    assign recip_c = $signed(RECIP_W'(RECIP));
    assign gain_c  = $signed(REM_W'(GAIN_Q13));
    assign x_in    = i_vec.x;

    // estimate is within one of the floor quotient in either direction
    always_comb begin
        q_est = DP_W'(r_prod >>> RECIP_SHIFT);
        num   = REM_W'(r_x1) <<< FRAC_BITS;
        n_rem = num - REM_W'(q_est) * gain_c;
    end

    always_comb begin
        n_polar.th = r_th2;
        if (r_rem < 0) begin
            n_polar.q = r_q2 - DP_W'(1);
        end else if (r_rem >= gain_c) begin
            n_polar.q = r_q2 + DP_W'(1);
        end else begin
            n_polar.q = r_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(x_in) * PROD_W'(recip_c);
            r_x1    <= x_in;
            r_th1   <= i_vec.th;
            r_q2    <= q_est;
            r_rem   <= n_rem;
            r_th2   <= r_th1;
            r_polar <= n_polar;
        end
    end

    assign o_valid = r_v3;
    assign o_polar = r_polar;

endmodule

`default_nettype wire

>>> src/cordic_cart_to_polar_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_cart_to_polar_top
// Cartesian-to-polar converter: quadrant fold, unrolled CORDIC vectoring
// pipeline, gain correction and saturation, with an output skid register.
// ----------------------------------------------------------------------------
// Path: fold register, the CORDIC iteration stages, the gain stages and the output register.
// Throughput: one item per cycle while the skid is empty; the pipeline advances as a whole.
// The one-entry skid behind the output register sets o_in_ready, which is a
// register and drops only while the skid holds an item.
// Reset clears the valid bits and the skid; payload registers are not reset.
module cordic_cart_to_polar_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  signed [cc2p_pkg::IO_W-1:0]   i_x_coord,
    input  wire  signed [cc2p_pkg::IO_W-1:0]   i_y_coord,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [cc2p_pkg::IO_W-1:0]   o_magnitude,
    output logic signed [cc2p_pkg::IO_W-1:0]   o_angle
);
    import cc2p_pkg::*;

    logic                     en;
    logic signed [DP_W-1:0]   ext_x;
    logic signed [DP_W-1:0]   ext_y;
    t_vec                     n_pre;
    logic                     r_pre_v;
    t_vec                     r_pre;

    logic                     w_v   [ITERATIONS+1];
    t_vec                     w_vec [ITERATIONS+1];

    logic                     g_valid;
    t_polar                   g_polar;
    logic signed [IO_W-1:0]   sat_mag;
    logic signed [IO_W-1:0]   sat_ang;

    logic                     r_out_v;
    logic signed [IO_W-1:0]   r_out_mag;
    logic signed [IO_W-1:0]   r_out_ang;
    logic                     r_skid_v;
    logic signed [IO_W-1:0]   r_skid_mag;
    logic signed [IO_W-1:0]   r_skid_ang;

    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // fold left half plane into the right one, preload the turn
    always_comb begin
        ext_x = DP_W'(i_x_coord);
        ext_y = DP_W'(i_y_coord);
        if (ext_x < 0 && ext_y < 0) begin
            n_pre.x  = -ext_y;
            n_pre.y  = ext_x;
            n_pre.th = ANG_W'(HALF_PI_NEG);
        end else if (ext_x < 0) begin
            n_pre.x  = ext_y;
            n_pre.y  = -ext_x;
            n_pre.th = ANG_W'(HALF_PI_POS);
        end else begin
            n_pre.x  = ext_x;
            n_pre.y  = ext_y;
            n_pre.th = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else if (en) begin
            r_pre_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre <= n_pre;
        end
    end

    assign w_v[0]   = r_pre_v;
    assign w_vec[0] = r_pre;

    for (genvar j = 0; j < ITERATIONS; j++) begin : g_iter
        cc2p_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (SHIFT_W'(j)),
            .i_valid (w_v[j]),
            .i_vec   (w_vec[j]),
            .o_valid (w_v[j+1]),
            .o_vec   (w_vec[j+1])
        );
    end

    cc2p_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_v[ITERATIONS]),
        .i_vec   (w_vec[ITERATIONS]),
        .o_valid (g_valid),
        .o_polar (g_polar)
    );

    always_comb begin
        if (g_polar.q > DP_W'(SAT_MAX)) begin
            sat_mag = IO_W'(SAT_MAX);
        end else if (g_polar.q < DP_W'(SAT_MIN)) begin
            sat_mag = IO_W'(SAT_MIN);
        end else begin
            sat_mag = IO_W'(g_polar.q);
        end
        if (g_polar.th > ANG_W'(SAT_MAX)) begin
            sat_ang = IO_W'(SAT_MAX);
        end else if (g_polar.th < ANG_W'(SAT_MIN)) begin
            sat_ang = IO_W'(SAT_MIN);
        end else begin
            sat_ang = IO_W'(g_polar.th);
        end
    end

    // output register with a one-item skid; the skid drains before the pipe moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out_v <= g_valid;
        end else if (g_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out_mag <= r_skid_mag;
                r_out_ang <= r_skid_ang;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out_mag <= sat_mag;
            r_out_ang <= sat_ang;
        end else begin
            r_skid_mag <= sat_mag;
            r_skid_ang <= sat_ang;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_magnitude = r_out_mag;
    assign o_angle     = r_out_ang;

    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while the output register is empty");

    a_skid_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_out_ready) |=> (!r_skid_v && r_out_v))
        else $error("skid item not moved to the output register");

    a_mag_nonneg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !r_out_mag[IO_W-1])
        else $error("negative magnitude");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_ang <= 16'sd27200 && r_out_ang >= -16'sd27200))
        else $error("angle outside the reachable range");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the CORDIC Cartesian-to-polar converter against a cycle-free
// predictor of the fold, the vectoring iterations, the gain correction and
// the saturation. A directed set of corner points is followed by random
// points. The sender works in bursts and the receiver stalls in patterns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IO_W          = cc2p_pkg::IO_W;
    localparam int N_ROT         = cc2p_pkg::ITERATIONS;
    localparam int QUARTER_POS   = 12867;
    localparam int QUARTER_NEG   = -12868;
    localparam int GAIN_CODE     = 13489;
    localparam int ONE_Q13       = 8192;
    localparam int MAG_MAX       = 32767;
    localparam int MAG_MIN       = -32768;
    localparam int N_RANDOM      = 830;
    localparam int SETTLE_CYCLES = N_ROT + 5 + 24;
    localparam int LIMIT_CYCLES  = 200000;

    typedef logic signed [IO_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   wait_idle;  // hold off until every result is back
    } t_point;

    typedef struct packed {
        t_coord mag;
        t_coord ang;
    } t_result;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_CHOKE
    } t_rx_mode;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    t_coord in_x      = '0;
    t_coord in_y      = '0;
    logic   out_ready = 1'b0;
    logic   in_ready;
    logic   out_valid;
    t_coord out_mag;
    t_coord out_ang;

    t_point  pending_points[$];
    t_result expected_polar[$];
    int      errors = 0;
    int      cycles = 0;

    cordic_cart_to_polar_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_x_coord   (in_x),
        .i_y_coord   (in_y),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_magnitude (out_mag),
        .o_angle     (out_ang)
    );

    always #2 clk = ~clk;

    function automatic int atan_step(int j);
        case (j)
            0:       return 6433;
            1:       return 3798;
            2:       return 2006;
            3:       return 1018;
            4:       return 511;
            5:       return 255;
            6:       return 127;
            7:       return 63;
            8:       return 31;
            9:       return 15;
            10:      return 7;
            11:      return 3;
            12:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int clamp16(longint v);
        if (v > MAG_MAX) return MAG_MAX;
        if (v < MAG_MIN) return MAG_MIN;
        return int'(v);
    endfunction

    function automatic t_result cart_to_polar(t_coord x, t_coord y);
        int      cx;
        int      cy;
        int      th;
        int      dx;
        int      dy;
        int      nx;
        longint  num;
        longint  q;
        t_result r;
        // fold left half plane into the right one
        if (x < 0 && y < 0) begin
            cx = -int'(y);
            cy = int'(x);
            th = QUARTER_NEG;
        end else if (x < 0) begin
            cx = int'(y);
            cy = -int'(x);
            th = QUARTER_POS;
        end else begin
            cx = int'(x);
            cy = int'(y);
            th = 0;
        end
        for (int j = 0; j < N_ROT && j < 16; j++) begin
            if (cy > 0) begin
                dx = (-cx) >>> j;
                dy = (-cy) >>> j;
                th = th + atan_step(j);
            end else begin
                dx = cx >>> j;
                dy = cy >>> j;
                th = th - atan_step(j);
            end
            nx = cx - dy;
            cy = cy + dx;
            cx = nx;
        end
        // floor division by the gain
        num = longint'(cx) * ONE_Q13;
        q = num / GAIN_CODE;
        if (num < 0 && (num % GAIN_CODE) != 0) q = q - 1;
        r.mag = t_coord'(clamp16(q));
        r.ang = t_coord'(clamp16(th));
        return r;
    endfunction

    function automatic t_point mk_point(int x, int y, logic hold);
        t_point p;
        p.x = t_coord'(x);
        p.y = t_coord'(y);
        p.wait_idle = hold;
        return p;
    endfunction

    function automatic void nx_swap(inout int a, inout int b);
        int t;
        t = a;
        a = b;
        b = t;
    endfunction

    function automatic t_point rand_point(logic hold);
        int kind;
        int x;
        int y;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            x = $urandom_range(0, 65535) - 32768;
            y = $urandom_range(0, 65535) - 32768;
        end else if (kind < 8) begin
            // stays inside the unsaturated disk
            x = $urandom_range(0, 22000) - 11000;
            y = $urandom_range(0, 22000) - 11000;
        end else if (kind < 9) begin
            x = $urandom_range(0, 128) - 64;
            y = $urandom_range(0, 128) - 64;
        end else begin
            x = $urandom_range(0, 65535) - 32768;
            case ($urandom_range(0, 3))
                0:       y = 0;
                1:       y = -1;
                2:       y = MAG_MAX;
                default: y = MAG_MIN;
            endcase
            if ($urandom_range(0, 1) == 1) begin
                nx_swap(x, y);
            end
        end
        return mk_point(x, y, hold);
    endfunction

    // sender: bursts of items separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk) begin : drive
        t_point p;
        logic   free;
        logic   take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_polar.push_back(cart_to_polar(in_x, in_y));
            end
            free = !in_valid || in_ready;
            take = 1'b0;
            if (free) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (pending_points.size() > 0) begin
                    take = !(pending_points[0].wait_idle && expected_polar.size() > 0);
                end
            end
            if (take) begin
                p = pending_points.pop_front();
                in_x     <= p.x;
                in_y     <= p.y;
                in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else if (free) begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;

    always @(posedge clk) begin : stall
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= ($urandom_range(0, 1) == 1);
            default:  out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk) begin : check
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_polar.size() == 0) begin
                $display("%0t: result with nothing expected: mag=%0d ang=%0d",
                         $time, out_mag, out_ang);
                errors = errors + 1;
            end else begin
                want = expected_polar.pop_front();
                if (out_mag !== want.mag) begin
                    $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                             $time, want.mag, out_mag);
                    errors = errors + 1;
                end
                if (out_ang !== want.ang) begin
                    $display("%0t: angle mismatch: expected %0d, actual %0d",
                             $time, want.ang, out_ang);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // corners: origin, axes, every quadrant, format extremes, saturation
        pending_points.push_back(mk_point(0, 0, 1'b0));
        pending_points.push_back(mk_point(1, 0, 1'b0));
        pending_points.push_back(mk_point(0, 1, 1'b0));
        pending_points.push_back(mk_point(-1, 0, 1'b0));
        pending_points.push_back(mk_point(0, -1, 1'b0));
        pending_points.push_back(mk_point(-1, -1, 1'b0));
        pending_points.push_back(mk_point(8192, 0, 1'b0));
        pending_points.push_back(mk_point(0, 8192, 1'b0));
        pending_points.push_back(mk_point(-8192, 0, 1'b0));
        pending_points.push_back(mk_point(0, -8192, 1'b0));
        pending_points.push_back(mk_point(8192, 8192, 1'b0));
        pending_points.push_back(mk_point(-8192, 8192, 1'b0));
        pending_points.push_back(mk_point(-8192, -8192, 1'b0));
        pending_points.push_back(mk_point(8192, -8192, 1'b0));
        pending_points.push_back(mk_point(MAG_MAX, 0, 1'b0));
        pending_points.push_back(mk_point(MAG_MIN, 0, 1'b0));
        pending_points.push_back(mk_point(0, MAG_MAX, 1'b0));
        pending_points.push_back(mk_point(0, MAG_MIN, 1'b0));
        pending_points.push_back(mk_point(MAG_MAX, MAG_MAX, 1'b0));
        pending_points.push_back(mk_point(MAG_MIN, MAG_MIN, 1'b0));
        pending_points.push_back(mk_point(MAG_MIN, MAG_MAX, 1'b0));
        pending_points.push_back(mk_point(MAG_MAX, MAG_MIN, 1'b0));
        pending_points.push_back(mk_point(-32768, -1, 1'b0));
        pending_points.push_back(mk_point(20000, 20000, 1'b0));
        for (int i = 0; i < N_RANDOM; i++) begin
            pending_points.push_back(rand_point(i == 0 || i == N_RANDOM / 2));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_points.size() > 0 || in_valid || expected_polar.size() > 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
